// ----- hdl/bed_pkg.sv -----
// Shared types and constants for the button event detector.
package bed_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned DelayWidth = 16;
    localparam int unsigned ApbAddrW   = 4;
    localparam int unsigned ApbDataW   = 32;
    localparam int unsigned RegIdxW    = 2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [RegIdxW-1:0] RegRepeatInitial = 2'd0;
    localparam logic [RegIdxW-1:0] RegRepeatPeriod  = 2'd1;
    localparam logic [RegIdxW-1:0] RegLongPress     = 2'd2;

    typedef struct packed {
        logic                 pin_level;
        logic [TimeWidth-1:0] now_ms;
        logic                 arm_ignore_release;
    } t_in_beat;

    typedef struct packed {
        logic press_event;
        logic release_event;
        logic long_press_event;
        logic held_now;
        logic long_held;
    } t_out_beat;

    typedef struct packed {
        logic [DelayWidth-1:0] repeat_initial_delay_ms;
        logic [DelayWidth-1:0] repeat_period_ms;
        logic [DelayWidth-1:0] long_press_delay_ms;
    } t_cfg;

endpackage

// ----- hdl/bed_core.sv -----
// Button state registers and the per-sample event logic.
module bed_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bed_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  bed_pkg::t_in_beat i_beat,
    output bed_pkg::t_out_beat o_result
);

    logic                             r_seen_sample;
    logic                             r_last_level;
    logic [bed_pkg::TimeWidth-1:0]    r_press_start_ms;
    logic [bed_pkg::TimeWidth-1:0]    r_next_repeat_ms;
    logic                             r_long_fired;
    logic                             r_ignore_release;

    logic                             n_press_start_valid;
    logic [bed_pkg::TimeWidth-1:0]    n_press_start_ms;
    logic [bed_pkg::TimeWidth-1:0]    n_next_repeat_ms;
    logic                             n_long_fired;
    logic                             n_ignore_release;

    logic                             prev_level;
    logic                             pressed;
    logic                             press_edge;
    logic                             release_edge;
    logic                             repeat_on;
    logic                             ignore_armed;
    logic [bed_pkg::TimeWidth-1:0]    initial_sum;
    logic [bed_pkg::TimeWidth-1:0]    repeat_base;
    logic [bed_pkg::TimeWidth-1:0]    period_sum;
    logic [bed_pkg::TimeWidth-1:0]    long_from_now;
    logic [bed_pkg::TimeWidth-1:0]    long_from_start;
    logic [bed_pkg::TimeWidth-1:0]    long_limit;
    logic                             repeat_ev;
    logic                             long_ev;
    logic                             release_ev;

    always_comb begin
        prev_level   = r_seen_sample ? r_last_level : i_beat.pin_level;
        pressed      = !i_beat.pin_level;
        press_edge   = pressed && prev_level;
        release_edge = i_beat.pin_level && !prev_level;
        repeat_on    = (i_cfg.repeat_initial_delay_ms != '0) && (i_cfg.repeat_period_ms != '0);

        // A release always leaves no recorded press; a press edge records the time.
        if (!pressed) begin
            n_press_start_ms = '0;
        end else if (press_edge) begin
            n_press_start_ms = i_beat.now_ms;
        end else begin
            n_press_start_ms = r_press_start_ms;
        end
        n_press_start_valid = (n_press_start_ms != '0);

        // The sums that depend on the new start time are formed from both
        // candidates in parallel, then selected by the press edge.
        initial_sum = i_beat.now_ms
                    + {{(bed_pkg::TimeWidth-bed_pkg::DelayWidth){1'b0}},
                       i_cfg.repeat_initial_delay_ms};
        period_sum  = i_beat.now_ms
                    + {{(bed_pkg::TimeWidth-bed_pkg::DelayWidth){1'b0}},
                       i_cfg.repeat_period_ms};
        repeat_base = (repeat_on && press_edge) ? initial_sum : r_next_repeat_ms;

        repeat_ev = repeat_on && n_press_start_valid && (i_beat.now_ms > repeat_base);
        n_next_repeat_ms = repeat_ev ? period_sum : repeat_base;

        long_from_now   = i_beat.now_ms
                        + {{(bed_pkg::TimeWidth-bed_pkg::DelayWidth){1'b0}},
                           i_cfg.long_press_delay_ms};
        long_from_start = r_press_start_ms
                        + {{(bed_pkg::TimeWidth-bed_pkg::DelayWidth){1'b0}},
                           i_cfg.long_press_delay_ms};
        long_limit      = press_edge ? long_from_now : long_from_start;

        long_ev = (i_cfg.long_press_delay_ms != '0) && !r_long_fired && pressed
                  && (i_beat.now_ms > long_limit);
        n_long_fired = pressed && (r_long_fired || long_ev);

        // An arm on the same sample as a release takes effect first.
        ignore_armed     = r_ignore_release || i_beat.arm_ignore_release;
        release_ev       = release_edge && !ignore_armed;
        n_ignore_release = ignore_armed && !release_edge;

        o_result.press_event      = press_edge || repeat_ev;
        o_result.release_event    = release_ev;
        o_result.long_press_event = long_ev;
        o_result.held_now         = pressed;
        o_result.long_held        = n_long_fired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_sample    <= 1'b0;
            r_last_level     <= 1'b1;
            r_press_start_ms <= '0;
            r_next_repeat_ms <= '0;
            r_long_fired     <= 1'b0;
            r_ignore_release <= 1'b0;
        end else if (i_accept) begin
            r_seen_sample    <= 1'b1;
            r_last_level     <= i_beat.pin_level;
            r_press_start_ms <= n_press_start_ms;
            r_next_repeat_ms <= n_next_repeat_ms;
            r_long_fired     <= n_long_fired;
            r_ignore_release <= n_ignore_release;
        end
    end

    a_long_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.long_press_event |-> o_result.held_now)
        else $error("long-press event on a released sample");

    a_press_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.press_event |-> o_result.held_now)
        else $error("press event on a released sample");

    a_release_clears_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_beat.pin_level |=> (r_press_start_ms == '0) && !r_long_fired)
        else $error("press state survived a released sample");

    a_release_edge_consumes_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && release_edge |=> !r_ignore_release)
        else $error("ignore flag left set after a release edge");

endmodule

// ----- hdl/button_event_detector_top.sv -----
// Button event detector top level: register port, core and result register.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_in_beat  (t_in_beat)
//   result    out        o_out_valid / i_out_ready o_out_beat (t_out_beat)
//   config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// Each sample is evaluated in the cycle it is accepted; its result is shown
// from the next cycle onwards in the result register.
// One sample per cycle is sustained while the result side takes every beat.
// A stalled result holds its register and lowers o_in_ready; the state is
// only updated for accepted beats. Reset clears the core state, the config and o_out_valid, not o_out_beat.
module button_event_detector_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bed_pkg::t_in_beat                 i_in_beat,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bed_pkg::t_out_beat                o_out_beat,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bed_pkg::ApbAddrW-1:0]      paddr,
    input  logic [bed_pkg::ApbDataW-1:0]      pwdata,
    output logic [bed_pkg::ApbDataW-1:0]      prdata,
    output logic                              pready
);

    bed_pkg::t_cfg             r_cfg;
    logic                      r_out_valid;
    bed_pkg::t_out_beat        r_out_beat;
    bed_pkg::t_out_beat        n_result;
    logic                      in_accept;
    logic                      cfg_write;
    logic [bed_pkg::RegIdxW-1:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[bed_pkg::ApbAddrW-1:bed_pkg::ApbAddrW-bed_pkg::RegIdxW];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                bed_pkg::RegRepeatInitial: begin
                    r_cfg.repeat_initial_delay_ms <= pwdata[bed_pkg::DelayWidth-1:0];
                end
                bed_pkg::RegRepeatPeriod: begin
                    r_cfg.repeat_period_ms <= pwdata[bed_pkg::DelayWidth-1:0];
                end
                bed_pkg::RegLongPress: begin
                    r_cfg.long_press_delay_ms <= pwdata[bed_pkg::DelayWidth-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bed_pkg::RegRepeatInitial: begin
                prdata = {{(bed_pkg::ApbDataW-bed_pkg::DelayWidth){1'b0}},
                          r_cfg.repeat_initial_delay_ms};
            end
            bed_pkg::RegRepeatPeriod: begin
                prdata = {{(bed_pkg::ApbDataW-bed_pkg::DelayWidth){1'b0}},
                          r_cfg.repeat_period_ms};
            end
            bed_pkg::RegLongPress: begin
                prdata = {{(bed_pkg::ApbDataW-bed_pkg::DelayWidth){1'b0}},
                          r_cfg.long_press_delay_ms};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // A new beat may enter whenever the result register is empty or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    bed_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (in_accept),
        .i_beat   (i_in_beat),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_beat <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
